// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ACHM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ACHM_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("forbidden condition");
`else
`define ACHM_ASSERT(lbl, clk, rstn, prop)
`define ACHM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- hw/rtl/achm_pkg.sv -----
package achm_pkg;

    localparam int IDX_W = 6;

    localparam logic REG_MERGE_ENABLE    = 1'b0;
    localparam logic REG_MAX_TIME_WINDOW = 1'b1;

    localparam logic [9:0] WINDOW_RESET = 10'd80;

    typedef struct packed {
        logic               adc;
        logic signed [19:0] tm;
        logic [2:0]         row;
        logic [6:0]         col;
    } hit_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        hit_t             hit;
        logic             has;
        logic [IDX_W-1:0] partner;
    } res_t;

    // column first, then signed time
    function automatic logic sorts_before(input hit_t a, input hit_t b);
        logic r;
        if (a.col != b.col)
            r = a.col < b.col;
        else
            r = a.tm < b.tm;
        return r;
    endfunction

endpackage

// ----- hw/rtl/adjacent_column_hit_merger.sv -----
// Flow: hits load one per cycle while loading; after the last hit the sort scans the one
//   hit_store read port once per stored hit, then each sorted position is read and checked,
//   each emitted hit is pushed, each partner probe is read and checked, and FIN ends the event;
//   each result is held back one position so the final one can carry last_result.
// Throughput: one event at a time; input stalls from the last hit until the final result
//   is loaded into the output register.
// Reset: asynchronous, active low; clears control state, merge_enable to 1, window to 80.
`include "assert_macros.svh"

module adjacent_column_hit_merger #(
    parameter int MAX_HITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [6:0]  column,
    input  logic [2:0]  row,
    input  logic signed [19:0] hit_time,
    input  logic        adc_present,
    input  logic        last_hit,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  hit_index,
    output logic [6:0]  out_column,
    output logic [2:0]  out_row,
    output logic signed [19:0] out_time,
    output logic        has_partner,
    output logic [5:0]  partner_index,
    output logic        empty_event,
    output logic        overflow,
    output logic        last_result
);

    localparam int IW = $clog2(MAX_HITS);
    localparam int CW = $clog2(MAX_HITS + 1);

    localparam logic [3:0] ST_LOAD = 4'd0;
    localparam logic [3:0] ST_SORT = 4'd1;
    localparam logic [3:0] ST_RDO  = 4'd2;
    localparam logic [3:0] ST_RDH  = 4'd3;
    localparam logic [3:0] ST_EVAL = 4'd4;
    localparam logic [3:0] ST_SRDO = 4'd5;
    localparam logic [3:0] ST_SRDH = 4'd6;
    localparam logic [3:0] ST_SCHK = 4'd7;
    localparam logic [3:0] ST_PUSH = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                ovf_reg, ovf_next;
    logic                merge_en_reg, merge_en_next;
    logic [9:0]          window_reg, window_next;
    logic [IW-1:0]       p_reg, p_next;
    logic [IW-1:0]       q_reg, q_next;
    logic [IW-1:0]       a_reg, a_next;
    logic [IW-1:0]       b_reg, b_next;
    achm_pkg::hit_t      ha_reg, ha_next;
    achm_pkg::res_t      res_reg, res_next;
    achm_pkg::res_t      pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;
    achm_pkg::res_t      out_res_reg, out_res_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_ovf_reg, out_ovf_next;
    logic                out_last_reg, out_last_next;

    logic           in_accept;
    logic           slot_free;
    logic [IW-1:0]  last_pos;
    achm_pkg::hit_t in_hit;

    // memory ports; sorted_order entries carry the taken mark above the index
    logic           store_we;
    logic [IW-1:0]  store_raddr;
    achm_pkg::hit_t store_rdata;
    logic [IW-1:0]  sort_hit_addr;
    logic           sort_ord_we;
    logic [IW-1:0]  sort_ord_addr;
    logic [IW-1:0]  sort_ord_data;
    logic           ord_we;
    logic [IW-1:0]  ord_waddr;
    logic [IW:0]    ord_wdata;
    logic [IW-1:0]  ord_raddr;
    logic [IW:0]    ord_rdata;
    logic           sort_start;
    logic           sort_done;

    // partner check on the hit arriving from hit_store
    logic signed [20:0] tdiff;
    logic [20:0]        tabs;
    logic               partner_ok;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_LOAD);
    assign slot_free = !out_valid_reg || !out_stall;
    assign last_pos  = IW'(cnt_reg - 1'b1);

    assign in_hit.adc = adc_present;
    assign in_hit.tm  = hit_time;
    assign in_hit.row = row;
    assign in_hit.col = column;

    assign store_we   = in_accept && (cnt_reg < CW'(MAX_HITS));
    assign sort_start = in_accept && last_hit;

    assign tdiff = {ha_reg.tm[19], ha_reg.tm} - {store_rdata.tm[19], store_rdata.tm};
    assign tabs  = tdiff[20] ? 21'(-tdiff) : 21'(tdiff);
    assign partner_ok = store_rdata.adc && (store_rdata.row == 3'd0)
                     && ({1'b0, store_rdata.col} == ({1'b0, ha_reg.col} + 8'd1))
                     && (tabs <= {11'd0, window_reg});

    achm_ram #(
        .WIDTH ($bits(achm_pkg::hit_t)),
        .DEPTH (MAX_HITS)
    ) u_hit_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (IW'(cnt_reg)),
        .wdata (in_hit),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    achm_ram #(
        .WIDTH (IW + 1),
        .DEPTH (MAX_HITS)
    ) u_sorted_order (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    achm_sorter #(
        .MAX_HITS (MAX_HITS)
    ) u_sorter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sort_start),
        .count    (cnt_reg + CW'(store_we)),
        .hit_addr (sort_hit_addr),
        .hit_data (store_rdata),
        .ord_we   (sort_ord_we),
        .ord_addr (sort_ord_addr),
        .ord_data (sort_ord_data),
        .done     (sort_done)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        merge_en_next   = merge_en_reg;
        window_next     = window_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        ha_next         = ha_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_res_next    = out_res_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        store_raddr     = p_reg;
        ord_raddr       = p_reg;
        // the sort writes every used entry with a clear taken mark
        ord_we          = sort_ord_we;
        ord_waddr       = sort_ord_addr;
        ord_wdata       = {1'b0, sort_ord_data};

        if (cfg_write_en)
        begin
            case (cfg_index)
                achm_pkg::REG_MERGE_ENABLE:    merge_en_next = cfg_data[0];
                achm_pkg::REG_MAX_TIME_WINDOW: window_next   = cfg_data;
                default:                       merge_en_next = merge_en_reg;
            endcase
        end

        case (state_reg)
            ST_LOAD:
            begin
                // store until full, flag the rest
                if (in_accept)
                begin
                    if (store_we)
                        cnt_next = cnt_reg + 1'b1;
                    else
                        ovf_next = 1'b1;
                    if (last_hit)
                        state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                store_raddr = sort_hit_addr;
                if (sort_done)
                begin
                    p_next     = '0;
                    state_next = ST_RDO;
                end
            end
            ST_RDO:
            begin
                ord_raddr  = p_reg;
                state_next = ST_RDH;
            end
            ST_RDH:
            begin
                a_next      = ord_rdata[IW-1:0];
                store_raddr = ord_rdata[IW-1:0];
                state_next  = ST_EVAL;
            end
            ST_EVAL:
            begin
                // sorted_order was read again at p, so its taken mark is on the port
                ha_next          = store_rdata;
                res_next.idx     = achm_pkg::IDX_W'(a_reg);
                res_next.hit     = store_rdata;
                res_next.has     = 1'b0;
                res_next.partner = '0;
                if ((store_rdata.row != 3'd0) || !merge_en_reg)
                begin
                    state_next = ST_PUSH;
                end
                else if (!store_rdata.adc || ord_rdata[IW])
                begin
                    // drop this hit and advance
                    if (p_reg == last_pos)
                        state_next = ST_FIN;
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_RDO;
                    end
                end
                else if (p_reg == last_pos)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    q_next     = p_reg + 1'b1;
                    state_next = ST_SRDO;
                end
            end
            ST_SRDO:
            begin
                ord_raddr  = q_reg;
                state_next = ST_SRDH;
            end
            ST_SRDH:
            begin
                b_next      = ord_rdata[IW-1:0];
                store_raddr = ord_rdata[IW-1:0];
                state_next  = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (partner_ok)
                begin
                    // mark the partner taken in its sorted_order entry
                    ord_we           = 1'b1;
                    ord_waddr        = q_reg;
                    ord_wdata        = {1'b1, b_reg};
                    res_next.has     = 1'b1;
                    res_next.partner = achm_pkg::IDX_W'(b_reg);
                    state_next       = ST_PUSH;
                end
                else if (q_reg == last_pos)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    q_next     = q_reg + 1'b1;
                    state_next = ST_SRDO;
                end
            end
            ST_PUSH:
            begin
                // hold one result back so the final one can carry last_result
                if (!pend_valid_reg || slot_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = pend_reg;
                        out_empty_next = 1'b0;
                        out_ovf_next   = ovf_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_next       = res_reg;
                    pend_valid_next = 1'b1;
                    if (p_reg == last_pos)
                        state_next = ST_FIN;
                    else
                    begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_RDO;
                    end
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_res_next    = pend_valid_reg ? pend_reg : '0;
                    out_empty_next  = !pend_valid_reg;
                    out_ovf_next    = ovf_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            merge_en_reg   <= 1'b1;
            window_reg     <= achm_pkg::WINDOW_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ovf_reg        <= ovf_next;
            merge_en_reg   <= merge_en_next;
            window_reg     <= window_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        q_reg         <= q_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        ha_reg        <= ha_next;
        res_reg       <= res_next;
        pend_reg      <= pend_next;
        out_res_reg   <= out_res_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit_index     = out_res_reg.idx;
    assign out_column    = out_res_reg.hit.col;
    assign out_row       = out_res_reg.hit.row;
    assign out_time      = out_res_reg.hit.tm;
    assign has_partner   = out_res_reg.has;
    assign partner_index = out_res_reg.partner;
    assign empty_event   = out_empty_reg;
    assign overflow      = out_ovf_reg;
    assign last_result   = out_last_reg;

    `ACHM_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > CW'(MAX_HITS))
    `ACHM_ASSERT(a_empty_zero, clk, rst_n, (out_valid_reg && out_empty_reg) |-> (out_last_reg && !out_res_reg.has))
    `ACHM_ASSERT(a_no_partner_idx, clk, rst_n, (out_valid_reg && !out_res_reg.has) |-> (out_res_reg.partner == '0))
    `ACHM_ASSERT(a_partner_row0, clk, rst_n, (out_valid_reg && out_res_reg.has) |-> (out_res_reg.hit.row == 3'd0))

endmodule

// ----- hw/rtl/achm_ram.sv -----
module achm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/achm_sorter.sv -----
module achm_sorter #(
    parameter int MAX_HITS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(MAX_HITS+1)-1:0] count,
    output logic [$clog2(MAX_HITS)-1:0]   hit_addr,
    input  achm_pkg::hit_t                hit_data,
    output logic                          ord_we,
    output logic [$clog2(MAX_HITS)-1:0]   ord_addr,
    output logic [$clog2(MAX_HITS)-1:0]   ord_data,
    output logic                          done
);

    localparam int IW = $clog2(MAX_HITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RDI  = 2'd1;
    localparam logic [1:0] S_CAPI = 2'd2;
    localparam logic [1:0] S_SCAN = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [IW-1:0]  j_reg, j_next;
    logic [IW-1:0]  rank_reg, rank_next;
    achm_pkg::hit_t cur_reg, cur_next;
    logic [IW-1:0]  last_pos;
    logic           inc;

    assign last_pos = IW'(count - 1'b1);

    // rank = hits that sort ahead, ties broken by load order
    assign inc = achm_pkg::sorts_before(hit_data, cur_reg)
              || (!achm_pkg::sorts_before(cur_reg, hit_data) && (j_reg < i_reg));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        rank_next  = rank_reg;
        cur_next   = cur_reg;
        hit_addr   = i_reg;
        ord_we     = 1'b0;
        ord_addr   = IW'(rank_reg + IW'(inc));
        ord_data   = i_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    state_next = S_RDI;
                end
            end
            S_RDI:
            begin
                state_next = S_CAPI;
            end
            S_CAPI:
            begin
                cur_next   = hit_data;
                hit_addr   = '0;
                j_next     = '0;
                rank_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (j_reg == last_pos)
                begin
                    ord_we = 1'b1;
                    if (i_reg == last_pos)
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RDI;
                    end
                end
                else
                begin
                    hit_addr  = j_reg + 1'b1;
                    j_next    = j_reg + 1'b1;
                    rank_next = IW'(rank_reg + IW'(inc));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        rank_reg <= rank_next;
        cur_reg  <= cur_next;
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY     = 64;
    localparam int STALL_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [6:0]         col;
        logic [2:0]         row;
        logic signed [19:0] tm;
        logic               adc;
        logic               last;
    } hit_item_t;

    typedef struct {
        logic [5:0]         idx;
        logic [6:0]         col;
        logic [2:0]         row;
        logic signed [19:0] tm;
        logic               has;
        logic [5:0]         partner;
        logic               empty;
        logic               ovf;
        logic               last;
    } merged_hit_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [6:0]  column;
    logic [2:0]  row;
    logic signed [19:0] hit_time;
    logic        adc_present;
    logic        last_hit;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  hit_index;
    logic [6:0]  out_column;
    logic [2:0]  out_row;
    logic signed [19:0] out_time;
    logic        has_partner;
    logic [5:0]  partner_index;
    logic        empty_event;
    logic        overflow;
    logic        last_result;

    adjacent_column_hit_merger #(.MAX_HITS(CAPACITY)) u_dut (.*);

    // Stimulus and expectation stores
    hit_item_t   pending_hits[$];
    merged_hit_t expected_hits[$];

    // Predictor state: the event being collected and the register copies
    hit_item_t   event_hits[$];
    logic        event_overflow;
    logic        merge_on;
    logic [9:0]  time_window;

    int          error_count;
    int          idle_cycles;
    logic        hold_off;
    int          hold_off_left;
    int          gap_left;
    int          burst_left;
    logic        in_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sort one closed event, run the merge pass and queue the resulting hits.
    task automatic merge_event();
        int order[$];
        bit taken[CAPACITY];
        int n;
        int j;
        int k;
        int diff;
        int cnt;
        int pidx;
        hit_item_t a;
        hit_item_t b;
        merged_hit_t r;
        n = event_hits.size();
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            j = i;
            order.push_back(i);
            while (j > 0 && (event_hits[i].col < event_hits[order[j-1]].col ||
                   (event_hits[i].col == event_hits[order[j-1]].col &&
                    event_hits[i].tm < event_hits[order[j-1]].tm)))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < CAPACITY; i++)
            taken[i] = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            a = event_hits[order[i]];
            r = '{idx: 6'(order[i]), col: a.col, row: a.row, tm: a.tm, has: 1'b0,
                  partner: 6'd0, empty: 1'b0, ovf: event_overflow, last: 1'b0};
            if (a.row == 0 && merge_on)
            begin
                if (!a.adc || taken[i])
                    continue;
                pidx = -1;
                for (k = i + 1; k < n && pidx < 0; k++)
                begin
                    b = event_hits[order[k]];
                    if (!b.adc || b.row != 0)
                        continue;
                    diff = a.tm - b.tm;
                    if (diff < 0)
                        diff = -diff;
                    if (int'(b.col) == int'(a.col) + 1 && diff <= int'(time_window))
                    begin
                        taken[k] = 1'b1;
                        pidx = order[k];
                    end
                end
                if (pidx >= 0)
                begin
                    r.has = 1'b1;
                    r.partner = 6'(pidx);
                end
            end
            expected_hits.push_back(r);
            cnt++;
        end
        if (cnt == 0)
        begin
            r = '{idx: 6'd0, col: 7'd0, row: 3'd0, tm: 20'sd0, has: 1'b0, partner: 6'd0,
                  empty: 1'b1, ovf: event_overflow, last: 1'b0};
            expected_hits.push_back(r);
        end
        expected_hits[expected_hits.size()-1].last = 1'b1;
        event_hits.delete();
        event_overflow = 1'b0;
    endtask

    function automatic hit_item_t make_hit(int c, int r, int t, int a, int l);
        hit_item_t h;
        h.col = 7'(c);
        h.row = 3'(r);
        h.tm = 20'(t);
        h.adc = 1'(a);
        h.last = 1'(l);
        return h;
    endfunction

    // Queue an event of n hits with merge-friendly content: clustered columns and times.
    task automatic add_event(int n, int spread);
        int base_col;
        int base_t;
        base_col = $urandom_range(0, 127);
        base_t = $signed($urandom_range(0, 20'hFFFFF) << 12) >>> 12;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                pending_hits.push_back(make_hit($urandom_range(0, 127), $urandom_range(0, 7),
                    $signed($urandom() << 12) >>> 12, $urandom_range(0, 1), int'(i == n - 1)));
            else
                pending_hits.push_back(make_hit(
                    (base_col + $urandom_range(0, 3)) & 127,
                    ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0,
                    base_t + $signed($urandom_range(0, 2 * spread)) - spread,
                    int'($urandom_range(0, 4) != 0), int'(i == n - 1)));
        end
    endtask

    // Write one register while idle; mirror it in the predictor.
    task automatic write_reg(logic which, logic [9:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        if (which == achm_pkg::REG_MERGE_ENABLE)
            merge_on = value[0];
        else
            time_window = value;
    endtask

    task automatic drain();
        while (pending_hits.size() != 0 || expected_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Driver: bursts of transactions with random gaps; hold the payload while stalled.
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
                ;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_hits.size() != 0)
            begin
                column <= pending_hits[0].col;
                row <= pending_hits[0].row;
                hit_time <= pending_hits[0].tm;
                adc_present <= pending_hits[0].adc;
                last_hit <= pending_hits[0].last;
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Accept side of the predictor: pop the driven item at the handshake.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            if (event_hits.size() < CAPACITY)
                event_hits.push_back(pending_hits[0]);
            else
                event_overflow = 1'b1;
            if (pending_hits[0].last)
                merge_event();
            void'(pending_hits.pop_front());
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_off)
        begin
            hold_off_left <= 3000;
            hold_off <= 1'b0;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 3) != 0);
    end

    // Monitor: compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        merged_hit_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result: hit_index %0d", hit_index);
                error_count++;
            end
            else
            begin
                e = expected_hits.pop_front();
                if (hit_index !== e.idx)
                begin
                    $error("hit_index exp %0d got %0d", e.idx, hit_index);
                    error_count++;
                end
                if (out_column !== e.col)
                begin
                    $error("out_column exp %0d got %0d", e.col, out_column);
                    error_count++;
                end
                if (out_row !== e.row)
                begin
                    $error("out_row exp %0d got %0d", e.row, out_row);
                    error_count++;
                end
                if (out_time !== e.tm)
                begin
                    $error("out_time exp %0d got %0d", e.tm, out_time);
                    error_count++;
                end
                if (has_partner !== e.has)
                begin
                    $error("has_partner exp %0d got %0d", e.has, has_partner);
                    error_count++;
                end
                if (partner_index !== e.partner)
                begin
                    $error("partner_index exp %0d got %0d", e.partner, partner_index);
                    error_count++;
                end
                if (empty_event !== e.empty)
                begin
                    $error("empty_event exp %0d got %0d", e.empty, empty_event);
                    error_count++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow exp %0d got %0d", e.ovf, overflow);
                    error_count++;
                end
                if (last_result !== e.last)
                begin
                    $error("last_result exp %0d got %0d", e.last, last_result);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int tw;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = achm_pkg::REG_MERGE_ENABLE;
        cfg_data = '0;
        in_valid = 1'b0;
        column = '0;
        row = '0;
        hit_time = '0;
        adc_present = 1'b0;
        last_hit = 1'b0;
        out_stall = 1'b0;
        event_overflow = 1'b0;
        merge_on = 1'b1;
        time_window = achm_pkg::WINDOW_RESET;
        error_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        hold_off_left = 0;
        gap_left = 0;
        burst_left = 0;
        in_taken = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: merge pair at the window edge, shared partner, drops, extremes.
        pending_hits.push_back(make_hit(5, 0, 100, 1, 0));
        pending_hits.push_back(make_hit(6, 0, 180, 1, 0));
        pending_hits.push_back(make_hit(5, 0, 110, 1, 0));
        pending_hits.push_back(make_hit(7, 0, 200, 0, 0));
        pending_hits.push_back(make_hit(127, 7, 524287, 1, 0));
        pending_hits.push_back(make_hit(0, 3, -524288, 0, 0));
        pending_hits.push_back(make_hit(6, 0, 181, 1, 1));
        // Empty event: only row-zero hits without ADC.
        pending_hits.push_back(make_hit(9, 0, -5, 0, 0));
        pending_hits.push_back(make_hit(10, 0, -5, 0, 1));
        // Single-hit event and equal keys.
        pending_hits.push_back(make_hit(20, 1, 7, 1, 1));
        pending_hits.push_back(make_hit(30, 0, 0, 1, 0));
        pending_hits.push_back(make_hit(30, 0, 0, 1, 0));
        pending_hits.push_back(make_hit(31, 0, 0, 1, 1));
        drain();

        // Overflow: one event beyond capacity.
        for (int i = 0; i < CAPACITY + 2; i++)
            pending_hits.push_back(make_hit($urandom_range(0, 127), $urandom_range(0, 7),
                $signed($urandom() << 12) >>> 12, $urandom_range(0, 1),
                int'(i == CAPACITY + 1)));
        drain();

        write_reg(achm_pkg::REG_MERGE_ENABLE, 10'd0);
        write_reg(achm_pkg::REG_MAX_TIME_WINDOW, 10'd0);
        add_event(6, 40);
        add_event(3, 40);
        drain();
        write_reg(achm_pkg::REG_MERGE_ENABLE, 10'd1);

        // Random phases through several window settings, the extremes among them.
        for (int phase = 0; phase < 4; phase++)
        begin
            tw = (phase == 0) ? 0 : (phase == 1) ? 1023 : $urandom_range(1, 300);
            write_reg(achm_pkg::REG_MAX_TIME_WINDOW, tw[9:0]);
            for (int e = 0; e < 10; e++)
                add_event($urandom_range(1, 8), (phase == 1) ? 600 : 120);
            if (phase == 2)
            begin
                // Long receiver hold-off while the sender keeps offering.
                hold_off = 1'b1;
            end
            drain();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- adjacent_column_hit_merger.f -----
+incdir+hw/rtl
hw/rtl/achm_pkg.sv
hw/rtl/achm_ram.sv
hw/rtl/achm_sorter.sv
hw/rtl/adjacent_column_hit_merger.sv
test/testbench.sv
